// ===== src/pcvo_pkg.sv =====
// ----------------------------------------------------------------------------
// pcvo_pkg
// Shared constants for the voxel occupancy grid: defaults, field widths,
// command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package pcvo_pkg;

  localparam int MAX_DIM_DEF    = 64;
  localparam int GRID_CELLS_DEF = 262144;

  localparam int ROW_BITS  = 64;
  localparam int ROW_SHIFT = 6;

  localparam int AXIS_W  = 7;
  localparam int INDEX_W = 18;
  localparam int IN_W    = 120;
  localparam int OUT_W   = 24;
  localparam int CFG_IW  = 3;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INV_SIZE = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SIZE_X   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SIZE_Y   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SIZE_Z   = 3'd6;

endpackage

// ===== src/point_cloud_voxel_occupancy.sv =====
// ----------------------------------------------------------------------------
// point_cloud_voxel_occupancy
// Occupancy grid of one bit per cell held in a row-organized block memory.
// Inserts quantize a Q16.16 point and mark its cell occupied, reads return a
// stored bit, and clear sets every cell free.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         command, coord_x, coord_y, coord_z, read_index
// m_axis    out        in_range, cell_index, cell_value
// cfg       in         register index and 32-bit write data
//
// An insert runs three pipelined axis conversions on one shared 32x16
// multiplier pair, two steps of index arithmetic and a read-modify-write of
// one 64-bit row. A read fetches one row and returns the addressed bit, and
// a clear sweeps one row per cycle over ceil(GRID_CELLS/64) rows.
// After reset the same row sweep runs before the first item is accepted.
// A result waiting on m_axis does not block acceptance of the next item.
// ----------------------------------------------------------------------------
module point_cloud_voxel_occupancy #(
  parameter int MAX_DIM    = pcvo_pkg::MAX_DIM_DEF,
  parameter int GRID_CELLS = pcvo_pkg::GRID_CELLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // command[1:0], coord_x[33:2], coord_y[65:34], coord_z[97:66],
  // read_index[115:98], zero fill above
  input  logic [pcvo_pkg::IN_W-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // in_range[0], cell_index[18:1], cell_value[19], zero fill above
  output logic [pcvo_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcvo_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [31:0]                       cfg_data
);
  import pcvo_pkg::*;

  localparam int DEPTH = (GRID_CELLS + ROW_BITS - 1) / ROW_BITS;
  localparam int RA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_CONV   = 8'b0000_0100,
    ST_LIN1   = 8'b0000_1000,
    ST_LIN2   = 8'b0001_0000,
    ST_ISSUE  = 8'b0010_0000,
    ST_MODIFY = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [31:0]         origin [3];
  logic [31:0]         inv_size;
  logic [AXIS_W-1:0]   size_cfg [3];
  logic [AXIS_W-1:0]   eff [3];

  logic [1:0]          cmd_q;
  logic [31:0]         coord_q [3];
  logic [1:0]          cnt;

  logic                s1_vld;
  logic [1:0]          s1_ax;
  logic                s1_neg;
  logic [31:0]         s1_mag;
  logic                s2_vld;
  logic [1:0]          s2_ax;
  logic                s2_neg;
  logic [47:0]         s2_pp_lo;
  logic [47:0]         s2_pp_hi;
  logic [AXIS_W-1:0]   ax_idx [3];
  logic                ax_ok [3];

  logic [32:0]         diff;
  logic [64:0]         prod_sum;
  logic [32:0]         rnd;

  logic [13:0]         sxy;
  logic [13:0]         yx;
  logic [31:0]         cell_addr;
  logic                cell_ok;
  logic [20:0]         lin;

  logic [RA-1:0]       clr_row;
  logic                clr_cmd;

  logic [ROW_BITS-1:0] grid_mem [DEPTH];
  logic [ROW_BITS-1:0] rd_row;
  logic [RA-1:0]       row_addr;

  logic                res_in_range;
  logic [INDEX_W-1:0]  res_index;
  logic                res_value;
  logic                out_free;
  logic                s_fire;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign row_addr      = cell_addr[ROW_SHIFT +: RA];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eff[i] = (32'(size_cfg[i]) > 32'(MAX_DIM)) ? AXIS_W'(MAX_DIM) : size_cfg[i];
    end
  end

  assign diff     = {coord_q[cnt][31], coord_q[cnt]} - {origin[cnt][31], origin[cnt]};
  assign prod_sum = {1'b0, s2_pp_hi, 16'd0} + {17'd0, s2_pp_lo} + 65'h0_8000_0000;
  assign rnd      = prod_sum[64:32];
  assign lin      = 21'(ax_idx[2]) * 21'(sxy) + 21'(yx);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      inv_size  <= 32'd65536;
      size_cfg[0] <= 7'd64;
      size_cfg[1] <= 7'd64;
      size_cfg[2] <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin[0]   <= cfg_data;
        REG_ORIGIN_Y: origin[1]   <= cfg_data;
        REG_ORIGIN_Z: origin[2]   <= cfg_data;
        REG_INV_SIZE: inv_size    <= cfg_data;
        REG_SIZE_X:   size_cfg[0] <= cfg_data[AXIS_W-1:0];
        REG_SIZE_Y:   size_cfg[1] <= cfg_data[AXIS_W-1:0];
        REG_SIZE_Z:   size_cfg[2] <= cfg_data[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // Axis conversion pipeline: subtract and magnitude, split multiply, round.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= (state == ST_CONV) && (cnt != 2'd3);
      s2_vld <= s1_vld;
    end
    s1_ax    <= cnt;
    s1_neg   <= diff[32];
    s1_mag   <= diff[32] ? 32'(-diff) : diff[31:0];
    s2_ax    <= s1_ax;
    s2_neg   <= s1_neg;
    s2_pp_lo <= 48'(s1_mag) * 48'(inv_size[15:0]);
    s2_pp_hi <= 48'(s1_mag) * 48'(inv_size[31:16]);
    if (s2_vld) begin
      ax_idx[s2_ax] <= rnd[AXIS_W-1:0];
      ax_ok[s2_ax]  <= !(s2_neg && (rnd != 33'd0)) && (rnd < {26'd0, eff[s2_ax]});
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      grid_mem[clr_row] <= '1;
    end else if ((state == ST_MODIFY) && (cmd_q == CMD_INSERT)) begin
      grid_mem[row_addr] <= rd_row & ~(ROW_BITS'(1) << cell_addr[ROW_SHIFT-1:0]);
    end
    if ((state == ST_ISSUE) && cell_ok) begin
      rd_row <= grid_mem[row_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_row       <= '0;
      clr_cmd       <= 1'b0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_row == RA'(DEPTH - 1)) begin
            clr_row <= '0;
            state   <= clr_cmd ? ST_DONE : ST_IDLE;
          end else begin
            clr_row <= clr_row + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            cmd_q        <= s_axis_tdata[1:0];
            coord_q[0]   <= s_axis_tdata[33:2];
            coord_q[1]   <= s_axis_tdata[65:34];
            coord_q[2]   <= s_axis_tdata[97:66];
            cell_addr    <= {14'd0, s_axis_tdata[115:98]};
            cell_ok      <= ({14'd0, s_axis_tdata[115:98]} < 32'(GRID_CELLS));
            cnt          <= '0;
            clr_cmd      <= 1'b1;
            res_in_range <= 1'b0;
            res_index    <= '0;
            res_value    <= 1'b0;
            unique case (s_axis_tdata[1:0])
              CMD_INSERT: state <= ST_CONV;
              CMD_READ:   state <= ST_ISSUE;
              CMD_CLEAR:  state <= ST_CLEAR;
              default:    state <= ST_DONE;
            endcase
          end
        end
        ST_CONV: begin
          if (cnt != 2'd3) begin
            cnt <= cnt + 1'b1;
          end
          if (s2_vld && (s2_ax == 2'd2)) begin
            state <= ST_LIN1;
          end
        end
        ST_LIN1: begin
          sxy   <= 14'(eff[0]) * 14'(eff[1]);
          yx    <= 14'(ax_idx[1]) * 14'(eff[0]) + 14'(ax_idx[0]);
          state <= ST_LIN2;
        end
        ST_LIN2: begin
          cell_addr <= 32'(lin);
          cell_ok   <= ax_ok[0] && ax_ok[1] && ax_ok[2] && (32'(lin) < 32'(GRID_CELLS));
          state     <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if ((cmd_q == CMD_INSERT) && !cell_ok) begin
            state <= ST_DONE;
          end else begin
            state <= ST_MODIFY;
          end
        end
        ST_MODIFY: begin
          res_index <= cell_addr[INDEX_W-1:0];
          if (cmd_q == CMD_INSERT) begin
            res_in_range <= 1'b1;
            res_value    <= 1'b0;
          end else begin
            res_value <= cell_ok ? rd_row[cell_addr[ROW_SHIFT-1:0]] : 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tdata <= {4'd0, res_value, res_index, res_in_range};
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/pcvo_checker.sv =====
// ----------------------------------------------------------------------------
// pcvo_checker
// Port-level checks for the voxel occupancy grid, bound to the top level.
// ----------------------------------------------------------------------------
module pcvo_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pcvo_pkg::OUT_W-1:0]    m_axis_tdata
);
  import pcvo_pkg::*;

  // A stalled result keeps its item.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An in-range insert result always reports its cell as occupied (cell_value clear).
  a_mark_occupied: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[19]))
    else $error("in_range and cell_value both set");

  // Reset drops any pending result.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // The grid sweep after reset holds off input.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready during grid sweep");

  // One item is worked at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an item was accepted");

endmodule

bind point_cloud_voxel_occupancy pcvo_checker u_pcvo_checker (.*);
